[design/tnrs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnrs_pkg: shared types and functions of the top-N row selector
// Row type, control struct of the cell chain, limit clamp and key compare.
// ----------------------------------------------------------------------------
package tnrs_pkg;

	localparam int MAX_KEEP = 64;
	localparam int NKEY     = 3;
	localparam int KEY_W    = 32;
	localparam int REF_W    = 32;
	localparam int CNT_W    = $clog2(MAX_KEEP + 1);
	localparam int LIM_W    = 7;
	localparam int KC_W     = 2;

	localparam logic [1:0] REG_LIMIT_N   = 2'd0;
	localparam logic [1:0] REG_KEY_COUNT = 2'd1;
	localparam logic [1:0] REG_DESC_MASK = 2'd2;

	typedef struct packed {
		logic signed [KEY_W-1:0] key0;
		logic signed [KEY_W-1:0] key1;
		logic signed [KEY_W-1:0] key2;
		logic [NKEY-1:0]         nulls;
		logic [REF_W-1:0]        ref_id;
	} row_t;

	typedef struct packed {
		logic ins;
		logic trunc;
		logic shift_out;
	} cell_ctl_t;

	function automatic logic [CNT_W-1:0] clamp_limit(input logic [LIM_W-1:0] v);
		logic [CNT_W-1:0] r;
		if (v == '0) begin
			r = CNT_W'(1);
		end else if (int'(v) > MAX_KEEP) begin
			r = CNT_W'(MAX_KEEP);
		end else begin
			r = CNT_W'(v);
		end
		return r;
	endfunction

	// true when row a strictly precedes row b
	function automatic logic precedes(input row_t a, input row_t b,
			input logic [KC_W-1:0] kc, input logic [NKEY-1:0] desc);
		logic [NKEY-1:0][KEY_W-1:0] ka;
		logic [NKEY-1:0][KEY_W-1:0] kb;
		logic res;
		logic done;
		ka = {a.key2, a.key1, a.key0};
		kb = {b.key2, b.key1, b.key0};
		res = 1'b0;
		done = 1'b0;
		for (int i = 0; i < NKEY; i++) begin
			if (!done && (i < int'(kc)) && !a.nulls[i] && !b.nulls[i]
					&& (ka[i] != kb[i])) begin
				res = desc[i] ? ($signed(ka[i]) > $signed(kb[i]))
					: ($signed(ka[i]) < $signed(kb[i]));
				done = 1'b1;
			end
		end
		return res;
	endfunction

endpackage

[design/tnrs_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnrs_cell: one slot of the sorted-insert chain
// Holds one kept row, compares it with the broadcast row, and takes the new
// row, its left neighbor's row, or its right neighbor's row when draining.
// ----------------------------------------------------------------------------
module tnrs_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tnrs_pkg::cell_ctl_t           ctl,
	input  tnrs_pkg::row_t                new_row,
	input  logic [tnrs_pkg::KC_W-1:0]     key_count,
	input  logic [tnrs_pkg::NKEY-1:0]     desc_mask,
	input  logic                          lim_ok,
	input  tnrs_pkg::row_t                left_row,
	input  logic                          left_veff,
	input  tnrs_pkg::row_t                right_row,
	input  logic                          right_valid,
	input  logic                          before_in,
	output logic                          before_out,
	output logic                          veff,
	output tnrs_pkg::row_t                row_q,
	output logic                          valid_q
);

	logic hit;
	logic take_new;
	logic take_left;

	assign veff       = valid_q && lim_ok;
	assign hit        = veff && tnrs_pkg::precedes(new_row, row_q, key_count, desc_mask);
	assign before_out = before_in || hit;
	assign take_new   = ctl.ins && lim_ok && !before_in && (hit || (!veff && left_veff));
	assign take_left  = ctl.ins && lim_ok && before_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.shift_out) begin
			valid_q <= right_valid;
		end else if (take_new) begin
			valid_q <= 1'b1;
		end else if (take_left) begin
			valid_q <= left_veff;
		end else if (ctl.ins || ctl.trunc) begin
			valid_q <= veff;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift_out) begin
			row_q <= right_row;
		end else if (take_new) begin
			row_q <= new_row;
		end else if (take_left) begin
			row_q <= left_row;
		end
	end

endmodule

[design/top_n_row_selector.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_n_row_selector: multi-key top-N row selection
// Keeps the first N rows in multi-key order in a chain of cells and emits
// them in order on the row marked end_of_rows.
//
//   channel  handshake              payload
//   item     item_valid/item_stall  sort_key0..2, null_flags, row_ref,
//                                   row_valid, end_of_rows
//   result   res_valid/res_stall    out_key0..2, out_null_flags, out_row_ref,
//                                   out_last
//   config   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// For each item, every cell compares against the row in parallel and the first
// preceding position ripples down the chain.
// After an end item, the chain shifts one kept row per taken result toward
// cell 0; items stall until the last kept row is taken, also while a result
// is stalled, or until the drain state finds the chain empty.
// Reset empties the chain; stored rows themselves are not cleared.
// ----------------------------------------------------------------------------
module top_n_row_selector (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_stall,
	input  logic signed [tnrs_pkg::KEY_W-1:0]  sort_key0,
	input  logic signed [tnrs_pkg::KEY_W-1:0]  sort_key1,
	input  logic signed [tnrs_pkg::KEY_W-1:0]  sort_key2,
	input  logic [tnrs_pkg::NKEY-1:0]          null_flags,
	input  logic [tnrs_pkg::REF_W-1:0]         row_ref,
	input  logic                               row_valid,
	input  logic                               end_of_rows,
	output logic                               res_valid,
	input  logic                               res_stall,
	output logic signed [tnrs_pkg::KEY_W-1:0]  out_key0,
	output logic signed [tnrs_pkg::KEY_W-1:0]  out_key1,
	output logic signed [tnrs_pkg::KEY_W-1:0]  out_key2,
	output logic [tnrs_pkg::NKEY-1:0]          out_null_flags,
	output logic [tnrs_pkg::REF_W-1:0]         out_row_ref,
	output logic                               out_last,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [1:0]                         cfg_index,
	input  logic [tnrs_pkg::LIM_W-1:0]         cfg_data
);

	localparam int N  = tnrs_pkg::MAX_KEEP;
	localparam int CW = tnrs_pkg::CNT_W;

	localparam logic ST_LOAD  = 1'b0;
	localparam logic ST_DRAIN = 1'b1;

	logic                        state_q;
	logic [tnrs_pkg::LIM_W-1:0]  limit_q;
	logic [tnrs_pkg::KC_W-1:0]   kc_q;
	logic [tnrs_pkg::NKEY-1:0]   desc_q;
	logic [CW-1:0]               lim;

	logic                        item_acc;
	logic                        res_acc;
	tnrs_pkg::cell_ctl_t         ctl;
	tnrs_pkg::row_t              new_row;

	tnrs_pkg::row_t              rows [N+1];
	logic [N:0]                  vld;
	logic [N-1:0]                veff;
	logic [N:0]                  hit_chain;
	logic [N-1:0]                lim_ok;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= tnrs_pkg::LIM_W'(tnrs_pkg::MAX_KEEP);
			kc_q    <= tnrs_pkg::KC_W'(1);
			desc_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tnrs_pkg::REG_LIMIT_N:   limit_q <= cfg_data;
				tnrs_pkg::REG_KEY_COUNT: kc_q    <= cfg_data[tnrs_pkg::KC_W-1:0];
				tnrs_pkg::REG_DESC_MASK: desc_q  <= cfg_data[tnrs_pkg::NKEY-1:0];
				default: ;
			endcase
		end
	end

	assign lim = tnrs_pkg::clamp_limit(limit_q);

	assign item_stall = (state_q == ST_DRAIN);
	assign item_acc   = item_valid && !item_stall;
	assign res_valid  = (state_q == ST_DRAIN) && vld[0];
	assign res_acc    = res_valid && !res_stall;

	assign ctl.ins       = item_acc && row_valid;
	assign ctl.trunc     = item_acc && end_of_rows;
	assign ctl.shift_out = res_acc;

	assign new_row.key0   = sort_key0;
	assign new_row.key1   = sort_key1;
	assign new_row.key2   = sort_key2;
	assign new_row.nulls  = null_flags;
	assign new_row.ref_id = row_ref;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (item_acc && end_of_rows) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!vld[0] || (res_acc && out_last)) begin
						state_q <= ST_LOAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	assign hit_chain[0] = 1'b0;
	assign vld[N]       = 1'b0;
	assign rows[N]      = new_row;

	for (genvar g = 0; g < N; g++) begin : g_cell
		tnrs_pkg::row_t left_row;
		logic           left_veff;

		assign lim_ok[g] = (CW'(g) < lim);

		if (g == 0) begin : g_head
			assign left_row  = new_row;
			assign left_veff = 1'b1;
		end else begin : g_body
			assign left_row  = rows[g-1];
			assign left_veff = veff[g-1];
		end

		tnrs_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.new_row     (new_row),
			.key_count   (kc_q),
			.desc_mask   (desc_q),
			.lim_ok      (lim_ok[g]),
			.left_row    (left_row),
			.left_veff   (left_veff),
			.right_row   (rows[g+1]),
			.right_valid (vld[g+1]),
			.before_in   (hit_chain[g]),
			.before_out  (hit_chain[g+1]),
			.veff        (veff[g]),
			.row_q       (rows[g]),
			.valid_q     (vld[g])
		);
	end

	assign out_key0       = rows[0].key0;
	assign out_key1       = rows[0].key1;
	assign out_key2       = rows[0].key2;
	assign out_null_flags = rows[0].nulls;
	assign out_row_ref    = rows[0].ref_id;
	assign out_last       = !vld[1];

`ifndef SYNTHESIS
	a_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot({1'b0, vld[N-1:0]} + (N+1)'(1)))
		else $error("kept rows are not contiguous from cell 0");

	a_limit: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ins |=> ($countones(vld[N-1:0]) <= int'($past(lim))))
		else $error("kept rows exceed the limit after an insertion");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(res_acc && out_last) |=> (state_q == ST_LOAD) && !vld[0])
		else $error("chain not empty after the last result transaction");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN && res_stall) |=> $stable(vld))
		else $error("chain moved while the result was stalled");
`endif

endmodule
